// ----- design/ipx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipx_pkg
// Shared types and constants of the indexed pixel palette expander.
// ----------------------------------------------------------------------------
package ipx_pkg;

  localparam int PaletteDepthDef = 256;
  localparam int CountWidthDef   = 20;

  localparam int OpW    = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW   = 16;

  typedef enum logic [OpW-1:0] {
    OP_PAL_WR = 2'd0,
    OP_START  = 2'd1,
    OP_BYTE   = 2'd2
  } ipx_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BPP       = 2'd0,
    REG_LSB_FIRST = 2'd1,
    REG_GROUP_LEN = 2'd2,
    REG_SKIP_BITS = 2'd3
  } ipx_reg_e;

  // controller -> datapath
  typedef struct packed {
    logic pal_wr;
    logic start;
    logic byte_in;
    logic step;
    logic move;
  } ipx_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic byte_run;
    logic step_done;
    logic pend;
    logic out_full;
  } ipx_sts_t;

endpackage
`default_nettype wire

// ----- design/ipx_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipx_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipx_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(Depth)-1:0]  waddr_i,
  input  wire [Width-1:0]          wdata_i,
  input  wire                      re_i,
  input  wire [$clog2(Depth)-1:0]  raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- design/ipx_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipx_ctrl
// Sequencer: takes input beats when idle, steps one source bit per cycle
// during a byte unless a fetched color waits, and moves it into the output register.
// ----------------------------------------------------------------------------
module ipx_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire [1:0]           operation_i,
  input  wire                 out_ready_i,
  output logic                in_ready_o,
  input  wire ipx_pkg::ipx_sts_t sts_i,
  output ipx_pkg::ipx_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   in_acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o         = '0;
    cmd_o.pal_wr  = in_acc && (operation_i == ipx_pkg::OP_PAL_WR);
    cmd_o.start   = in_acc && (operation_i == ipx_pkg::OP_START);
    cmd_o.byte_in = in_acc && (operation_i == ipx_pkg::OP_BYTE);
    // a fetched color leaves the RAM register once the output slot is free
    cmd_o.move    = sts_i.pend && (!sts_i.out_full || out_ready_i);
    cmd_o.step    = (state_q == ST_RUN) && (!sts_i.pend || cmd_o.move);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.byte_in && sts_i.byte_run) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (cmd_o.step && sts_i.step_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/ipx_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipx_dpath
// Bit unpacking, index gathering, row skip counting, palette RAM and the
// output register.
// ----------------------------------------------------------------------------
module ipx_dpath #(
  parameter int PaletteDepth = ipx_pkg::PaletteDepthDef,
  parameter int CountWidth   = ipx_pkg::CountWidthDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [ipx_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [ipx_pkg::CfgW-1:0]      cfg_wdata_i,
  input  wire [7:0]                    palette_index_i,
  input  wire [15:0]                   palette_color_i,
  input  wire [19:0]                   pixel_count_i,
  input  wire [7:0]                    source_byte_i,
  input  wire                          out_ready_i,
  output logic                         out_valid_o,
  output logic [15:0]                  pixel_color_o,
  output logic                         last_pixel_o,
  input  wire ipx_pkg::ipx_cmd_t       cmd_i,
  output ipx_pkg::ipx_sts_t            sts_o
);

  localparam int AddrW = $clog2(PaletteDepth);

  // configuration
  logic [3:0]  bpp_q;
  logic        lsb_q;
  logic [15:0] gl_q;
  logic [15:0] skip_q;

  // run state
  logic [7:0]            byte_q;
  logic [2:0]            q_q;
  logic [12:0]           drop_q;
  logic [7:0]            acc_q;
  logic [3:0]            gath_q;
  logic [15:0]           grp_q;
  logic [CountWidth-1:0] rem_q;

  // fetch and output
  logic        pend_q, oob_q, plast_q, out_valid_q;
  logic [15:0] rdata;

  // step logic
  logic [3:0]            bpp_eff;
  logic [2:0]            sh;
  logic [7:0]            acc_n;
  logic [3:0]            gath_n;
  logic [16:0]           grp_inc;
  logic                  wrap;
  logic [15:0]           grp_n;
  logic [16:0]           q_adv;
  logic                  over;
  logic [13:0]           drop_full;
  logic                  emit;
  logic [CountWidth-1:0] rem_n;
  logic                  fetch;
  logic                  pal_we;

  always_comb begin
    if (bpp_q == 4'd0)      bpp_eff = 4'd1;
    else if (bpp_q > 4'd8)  bpp_eff = 4'd8;
    else                    bpp_eff = bpp_q;
  end

  always_comb begin
    sh        = lsb_q ? q_q : 3'd7 - q_q;
    acc_n     = {acc_q[6:0], byte_q[sh]};
    gath_n    = gath_q + 4'd1;
    grp_inc   = {1'b0, grp_q} + 17'd1;
    wrap      = (gl_q != 16'd0) && (grp_inc >= {1'b0, gl_q});
    if (gl_q == 16'd0) grp_n = grp_q;
    else if (wrap)     grp_n = 16'd0;
    else               grp_n = grp_inc[15:0];
    // skip lands before the usual advance by one bit
    q_adv     = {14'd0, q_q} + (wrap ? {1'b0, skip_q} : 17'd0) + 17'd1;
    over      = |q_adv[16:3];
    drop_full = q_adv[16:3] - 14'd1;
    emit      = (gath_n >= bpp_eff);
    rem_n     = emit ? rem_q - CountWidth'(1) : rem_q;
  end

  assign fetch  = cmd_i.step && emit;
  assign pal_we = cmd_i.pal_wr && ({1'b0, palette_index_i} < 9'(PaletteDepth));

  assign sts_o.byte_run  = (rem_q != '0) && (drop_q == 13'd0);
  assign sts_o.step_done = over || (rem_n == '0);
  assign sts_o.pend      = pend_q;
  assign sts_o.out_full  = out_valid_q;

  ipx_ram #(
    .Width (16),
    .Depth (PaletteDepth)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (palette_index_i[AddrW-1:0]),
    .wdata_i (palette_color_i),
    .re_i    (fetch),
    .raddr_i (acc_n[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q  <= 4'd1;
      lsb_q  <= 1'b0;
      gl_q   <= 16'd0;
      skip_q <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ipx_pkg::REG_BPP:       bpp_q  <= cfg_wdata_i[3:0];
        ipx_pkg::REG_LSB_FIRST: lsb_q  <= cfg_wdata_i[0];
        ipx_pkg::REG_GROUP_LEN: gl_q   <= cfg_wdata_i;
        ipx_pkg::REG_SKIP_BITS: skip_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_in && sts_o.byte_run) begin
      byte_q <= source_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q    <= 3'd0;
      drop_q <= 13'd0;
      acc_q  <= 8'd0;
      gath_q <= 4'd0;
      grp_q  <= 16'd0;
      rem_q  <= '0;
    end else if (cmd_i.start) begin
      q_q    <= 3'd0;
      drop_q <= 13'd0;
      acc_q  <= 8'd0;
      gath_q <= 4'd0;
      grp_q  <= 16'd0;
      rem_q  <= CountWidth'(pixel_count_i);
    end else if (cmd_i.byte_in) begin
      // whole bytes covered by a skip are swallowed here
      if ((rem_q != '0) && (drop_q != 13'd0)) drop_q <= drop_q - 13'd1;
    end else if (cmd_i.step) begin
      acc_q  <= emit ? 8'd0 : acc_n;
      gath_q <= emit ? 4'd0 : gath_n;
      grp_q  <= grp_n;
      q_q    <= q_adv[2:0];
      rem_q  <= rem_n;
      if (over) drop_q <= drop_full[12:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fetch)           pend_q <= 1'b1;
      else if (cmd_i.move) pend_q <= 1'b0;
      if (cmd_i.move)       out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch) begin
      oob_q   <= ({1'b0, acc_n} >= 9'(PaletteDepth));
      plast_q <= (rem_n == '0);
    end
    if (cmd_i.move) begin
      pixel_color_o <= oob_q ? 16'd0 : rdata;
      last_pixel_o  <= plast_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- design/indexed_pixel_palette_expander_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_pixel_palette_expander_top
// Expands packed palette indexes into 16-bit colors.
// ----------------------------------------------------------------------------
// Input channel (valid/ready): one beat carries an operation - palette
// write, run start with a pixel count, or one packed source byte.
// Output channel (valid/ready): one beat per pixel, color plus a flag on the
// final pixel of the run.
// Palette writes and run starts never hold off the next beat. A source byte
// is accepted and then walked bit by bit (at most 8 bits); the bit unpacker
// reads one bit per cycle unless a fetched color waits for the output slot.
// A byte swallowed by a skip or outside a run is only accepted, not walked.
// Peak rate is one pixel per cycle.
// After its last bit is stepped, a pixel's color passes through the
// registered palette RAM read and then the output register.
// When the receiver stalls, one color waits in the output register and one
// in the RAM read register; the bit unpacker then halts until space frees.
// Input is not taken while a byte is being walked.
// Reset clears the configuration to defaults and the run counters, but not
// the source byte register; palette contents are undefined until written.
// ----------------------------------------------------------------------------
module indexed_pixel_palette_expander_top #(
  parameter int PaletteDepth = ipx_pkg::PaletteDepthDef,
  parameter int CountWidth   = ipx_pkg::CountWidthDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [ipx_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [ipx_pkg::CfgW-1:0]      cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire [1:0]                    operation_i,
  input  wire [7:0]                    palette_index_i,
  input  wire [15:0]                   palette_color_i,
  input  wire [19:0]                   pixel_count_i,
  input  wire [7:0]                    source_byte_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [15:0]                  pixel_color_o,
  output logic                         last_pixel_o
);

  ipx_pkg::ipx_cmd_t cmd;
  ipx_pkg::ipx_sts_t sts;

  ipx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ipx_dpath #(
    .PaletteDepth (PaletteDepth),
    .CountWidth   (CountWidth)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .palette_index_i (palette_index_i),
    .palette_color_i (palette_color_i),
    .pixel_count_i   (pixel_count_i),
    .source_byte_i   (source_byte_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .pixel_color_o   (pixel_color_o),
    .last_pixel_o    (last_pixel_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule
`default_nettype wire

// ----- design/ipx_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipx_checker
// Port-level checks of the palette expander, bound to the top level.
// ----------------------------------------------------------------------------
module ipx_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_o,
  input wire [1:0]  operation_i,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [15:0] pixel_color_o,
  input wire        last_pixel_o
);

  // output beat holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(pixel_color_o) && $stable(last_pixel_o))
    else $error("output payload changed while stalled");

  // only a source byte can make the block busy
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && (operation_i == ipx_pkg::OP_BYTE)))
    else $error("input stalled without a source byte");

  a_cmd_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i != ipx_pkg::OP_BYTE) |=> in_ready_o)
    else $error("palette write or start held off the next beat");

endmodule

bind indexed_pixel_palette_expander_top ipx_checker u_ipx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .operation_i   (operation_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pixel_color_o (pixel_color_o),
  .last_pixel_o  (last_pixel_o)
);
`default_nettype wire
